/* src/isd_pkg.sv */
`default_nettype none
package isd_pkg;

   // csr index codes, in register order
   typedef enum logic [1:0] {
      CSR_ACC_THRESHOLD_SQ  = 2'd0,
      CSR_GYRO_THRESHOLD_SQ = 2'd1,
      CSR_MIN_INTERVAL_MS   = 2'd2
   } isd_csr_type;

   // request operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic [31:0] ACC_THRESHOLD_RESET  = 32'd386554921;
   localparam logic [31:0] GYRO_THRESHOLD_RESET = 32'd409600;
   localparam logic [15:0] MIN_INTERVAL_RESET   = 16'd300;

   // one axis squared: at most 2^30, so 31 bits
   localparam int SQ_W = 31;
   localparam int AXES = 3;

   typedef struct packed {
      logic [31:0] acc_threshold_sq;
      logic [31:0] gyro_threshold_sq;
      logic [15:0] min_interval_ms;
   } isd_cfg_type;

   // control travelling with the squared lanes
   typedef struct packed {
      logic        valid;
      logic        operation;
      logic [31:0] time_ms;
   } isd_ctrl_type;

endpackage
`default_nettype wire

/* src/isd_square_lane.sv */
`default_nettype none
module isd_square_lane
   import isd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic signed [15:0] sample,
   output logic        [SQ_W-1:0]  square
);

   logic signed [31:0] product;
   logic [SQ_W-1:0]    square_ff;
   logic [SQ_W-1:0]    square_in;

   // square one axis; the result never exceeds 2^30
   always_comb begin
      product   = sample * sample;
      square_in = product[SQ_W-1:0];
   end

   // hold the square until the next request loads the lane
   always_ff @(posedge clock) begin
      if (load) begin
         square_ff <= square_in;
      end
   end

   assign square = square_ff;

endmodule
`default_nettype wire

/* src/isd_merge.sv */
`default_nettype none
module isd_merge
   import isd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire isd_ctrl_type      ctrl,
   input  wire isd_cfg_type       cfg,
   input  wire logic [SQ_W-1:0]   acc_sq [AXES],
   input  wire logic [SQ_W-1:0]   gyro_sq [AXES],
   output logic                   rsp_valid,
   output logic [15:0]            step_total,
   output logic                   step_seen
);

   logic        prev_above_ff, prev_above_in;
   logic [31:0] last_step_ff, last_step_in;
   logic [15:0] steps_ff, steps_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] total_ff;
   logic        seen_ff, seen_in;

   logic [31:0] acc_mag;
   logic [31:0] gyro_mag;
   logic [31:0] elapsed;
   logic        above;
   logic        fire;
   logic        advance;

   // combine lanes: sums of three squares fit in 32 bits
   always_comb begin
      acc_mag  = {1'b0, acc_sq[0]} + {1'b0, acc_sq[1]} + {1'b0, acc_sq[2]};
      gyro_mag = {1'b0, gyro_sq[0]} + {1'b0, gyro_sq[1]} + {1'b0, gyro_sq[2]};
      elapsed  = ctrl.time_ms - last_step_ff;
      above    = acc_mag > cfg.acc_threshold_sq;
      fire     = above && !prev_above_ff && (gyro_mag > cfg.gyro_threshold_sq)
                 && (elapsed > {16'd0, cfg.min_interval_ms});
      advance  = ctrl.valid && take;
   end

   // next state: clear zeroes only the count
   always_comb begin
      prev_above_in = prev_above_ff;
      last_step_in  = last_step_ff;
      steps_in      = steps_ff;
      seen_in       = 1'b0;
      if (ctrl.operation == OP_CLEAR) begin
         steps_in = 16'd0;
      end else begin
         prev_above_in = above;
         if (fire) begin
            steps_in     = steps_ff + 16'd1;
            last_step_in = ctrl.time_ms;
            seen_in      = 1'b1;
         end
      end
      rsp_valid_in = take ? ctrl.valid : rsp_valid_ff;
   end

   // commit state and hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_above_ff <= 1'b0;
         last_step_ff  <= 32'd0;
         steps_ff      <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            prev_above_ff <= prev_above_in;
            last_step_ff  <= last_step_in;
            steps_ff      <= steps_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         total_ff <= steps_in;
         seen_ff  <= seen_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign step_total = total_ff;
   assign step_seen  = seen_ff;

endmodule
`default_nettype wire

/* src/imu_step_detector_unit.sv */
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | operation, acc_x/y/z, gyro_x/y/z, time_ms
// rsp     | out       | rsp_valid / rsp_ready | step_total, step_seen
// csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One request per cycle sustained while results are taken. The six squaring lanes
// register at acceptance; the merge and state update register when the merge
// stage is free, and the result is valid from that edge.
// Reset: synchronous, restores the default thresholds and zeroes the count.
// A stalled result holds the merge stage; one further request still enters
// the lanes, after which req_ready drops until the result is taken.
// csr_ready is always high.
`default_nettype none
module imu_step_detector_unit
   import isd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_operation,
   input  wire logic signed [15:0] req_acc_x,
   input  wire logic signed [15:0] req_acc_y,
   input  wire logic signed [15:0] req_acc_z,
   input  wire logic signed [15:0] req_gyro_x,
   input  wire logic signed [15:0] req_gyro_y,
   input  wire logic signed [15:0] req_gyro_z,
   input  wire logic        [31:0] req_time_ms,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic             [15:0] rsp_step_total,
   output logic                    rsp_step_seen,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic         [1:0] csr_index,
   input  wire logic        [31:0] csr_data
);

   isd_cfg_type  cfg_ff, cfg_in;
   isd_ctrl_type ctrl_ff, ctrl_in;
   logic         take;
   logic         load;
   logic [SQ_W-1:0] acc_sq [AXES];
   logic [SQ_W-1:0] gyro_sq [AXES];
   logic signed [15:0] acc_axis [AXES];
   logic signed [15:0] gyro_axis [AXES];

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (isd_csr_type'(csr_index))
            CSR_ACC_THRESHOLD_SQ:  cfg_in.acc_threshold_sq  = csr_data;
            CSR_GYRO_THRESHOLD_SQ: cfg_in.gyro_threshold_sq = csr_data;
            CSR_MIN_INTERVAL_MS:   cfg_in.min_interval_ms   = csr_data[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.acc_threshold_sq  <= ACC_THRESHOLD_RESET;
         cfg_ff.gyro_threshold_sq <= GYRO_THRESHOLD_RESET;
         cfg_ff.min_interval_ms   <= MIN_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline flow: merge stage frees when its result is empty or taken
   always_comb begin
      take      = !rsp_valid || rsp_ready;
      req_ready = !ctrl_ff.valid || take;
      load      = req_valid && req_ready;
      ctrl_in   = ctrl_ff;
      if (take) begin
         ctrl_in.valid = 1'b0;
      end
      if (load) begin
         ctrl_in.valid     = 1'b1;
         ctrl_in.operation = req_operation;
         ctrl_in.time_ms   = req_time_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff.operation <= ctrl_in.operation;
      ctrl_ff.time_ms   <= ctrl_in.time_ms;
   end

   // squaring lanes, one per axis
   assign acc_axis[0]  = req_acc_x;
   assign acc_axis[1]  = req_acc_y;
   assign acc_axis[2]  = req_acc_z;
   assign gyro_axis[0] = req_gyro_x;
   assign gyro_axis[1] = req_gyro_y;
   assign gyro_axis[2] = req_gyro_z;

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      isd_square_lane u_acc_lane (
         .clock  (clock),
         .load   (load),
         .sample (acc_axis[g]),
         .square (acc_sq[g])
      );
      isd_square_lane u_gyro_lane (
         .clock  (clock),
         .load   (load),
         .sample (gyro_axis[g]),
         .square (gyro_sq[g])
      );
   end

   // merge lanes, update step state, hold the result
   isd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .ctrl       (ctrl_ff),
      .cfg        (cfg_ff),
      .acc_sq     (acc_sq),
      .gyro_sq    (gyro_sq),
      .rsp_valid  (rsp_valid),
      .step_total (rsp_step_total),
      .step_seen  (rsp_step_seen)
   );

   // checks
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid && !ctrl_ff.valid)
      else $error("pipeline not empty after reset");

   a_ready_when_free : assert property (@(posedge clock) disable iff (reset)
      !ctrl_ff.valid |-> req_ready)
      else $error("request refused with empty lanes");

   a_clear_result : assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.valid && take && ctrl_ff.operation == OP_CLEAR
      |=> rsp_valid && rsp_step_total == 16'd0 && !rsp_step_seen)
      else $error("clear request did not give a zero count");

   a_seen_counts : assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.valid && take |=> rsp_valid)
      else $error("merged request produced no result");

endmodule
`default_nettype wire

/* tb/tb_imu_step_detector_unit.sv */
`timescale 1ns / 1ps

module tb_imu_step_detector_unit;
   import isd_pkg::*;

   // index with no register behind it
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [15:0] total;
      logic        seen;
   } step_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_operation;
   logic signed [15:0] req_acc_x;
   logic signed [15:0] req_acc_y;
   logic signed [15:0] req_acc_z;
   logic signed [15:0] req_gyro_x;
   logic signed [15:0] req_gyro_y;
   logic signed [15:0] req_gyro_z;
   logic        [31:0] req_time_ms;
   logic               rsp_valid;
   logic               rsp_ready;
   logic        [15:0] rsp_step_total;
   logic               rsp_step_seen;
   logic               csr_valid;
   logic               csr_ready;
   logic         [1:0] csr_index;
   logic        [31:0] csr_data;

   // predicted block state and registers
   isd_cfg_type  model_cfg;
   logic         model_prev_above;
   logic [31:0]  model_last_step_ms;
   logic [15:0]  model_steps;

   step_result_type expected_steps[$];
   int unsigned  mismatch_count;
   bit           gaps_enabled;
   int unsigned  rsp_hold_cycles;
   logic [31:0]  walk_time;

   imu_step_detector_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_acc_x      (req_acc_x),
      .req_acc_y      (req_acc_y),
      .req_acc_z      (req_acc_z),
      .req_gyro_x     (req_gyro_x),
      .req_gyro_y     (req_gyro_y),
      .req_gyro_z     (req_gyro_z),
      .req_time_ms    (req_time_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_step_total (rsp_step_total),
      .rsp_step_seen  (rsp_step_seen),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // end the run if the handshakes never complete
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // exact sum of squares of three signed axes
   function automatic logic [33:0] mag_sq(input logic signed [15:0] a, b, c);
      longint x, y, z;
      x = a;
      y = b;
      z = c;
      return 34'(x * x + y * y + z * z);
   endfunction

   // advance the predicted state by one request and return its result
   function automatic step_result_type predict_step(input logic op,
         input logic signed [15:0] ax, ay, az, gx, gy, gz, input logic [31:0] t);
      step_result_type res;
      logic         above;
      logic [31:0]  elapsed;
      res.seen = 1'b0;
      if (op == OP_CLEAR) begin
         model_steps = '0;
      end else begin
         above = mag_sq(ax, ay, az) > {2'b00, model_cfg.acc_threshold_sq};
         if (above && !model_prev_above &&
             mag_sq(gx, gy, gz) > {2'b00, model_cfg.gyro_threshold_sq}) begin
            elapsed = t - model_last_step_ms;
            if (elapsed > {16'h0000, model_cfg.min_interval_ms}) begin
               model_steps        = model_steps + 16'd1;
               model_last_step_ms = t;
               res.seen           = 1'b1;
            end
         end
         model_prev_above = above;
      end
      res.total = model_steps;
      return res;
   endfunction

   // check results, predict accepted requests, track register writes
   always @(posedge clock) begin : step_monitor
      step_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_steps.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: total %0d seen %0b",
                           rsp_step_total, rsp_step_seen);
               mismatch_count++;
            end else begin
               want = expected_steps.pop_front();
               if (rsp_step_total !== want.total || rsp_step_seen !== want.seen) begin
                  if (mismatch_count < 10)
                     $display("step mismatch: total exp %0d got %0d, seen exp %0b got %0b",
                              want.total, rsp_step_total, want.seen, rsp_step_seen);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_steps.push_back(predict_step(req_operation, req_acc_x, req_acc_y,
                                                  req_acc_z, req_gyro_x, req_gyro_y,
                                                  req_gyro_z, req_time_ms));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACC_THRESHOLD_SQ:  model_cfg.acc_threshold_sq  = csr_data;
               CSR_GYRO_THRESHOLD_SQ: model_cfg.gyro_threshold_sq = csr_data;
               CSR_MIN_INTERVAL_MS:   model_cfg.min_interval_ms   = csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   // result side: random gaps, plus a long hold-off when requested
   initial begin : result_taker
      int unsigned wait_cycles;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = rsp_hold_cycles + (gaps_enabled ? $urandom_range(18, 0) : 0);
         rsp_hold_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // offer one request; returns at a falling edge with valid still high
   task automatic send_request(input logic op,
         input logic signed [15:0] ax, ay, az, gx, gy, gz, input logic [31:0] t);
      int unsigned gap;
      gap = gaps_enabled ? $urandom_range(18, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_acc_x     <= ax;
      req_acc_y     <= ay;
      req_acc_z     <= az;
      req_gyro_x    <= gx;
      req_gyro_y    <= gy;
      req_gyro_z    <= gz;
      req_time_ms   <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_sample(input logic signed [15:0] ax, ay, az, gx, gy, gz,
                              input logic [31:0] t);
      send_request(OP_SAMPLE, ax, ay, az, gx, gy, gz, t);
   endtask

   task automatic send_clear;
      send_request(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), $urandom);
   endtask

   // drop valid and hold until every result has been taken
   task automatic wait_drained;
      if (req_valid) req_valid <= 1'b0;
      @(negedge clock);
      while (expected_steps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [31:0] acc_thr, gyro_thr, min_data);
      write_csr(CSR_ACC_THRESHOLD_SQ, acc_thr);
      write_csr(CSR_GYRO_THRESHOLD_SQ, gyro_thr);
      write_csr(CSR_MIN_INTERVAL_MS, min_data);
   endtask

   function automatic logic signed [15:0] axis_upto(input int unsigned amp);
      int v;
      v = int'($urandom_range(2 * amp, 0)) - int'(amp);
      if (v > 32767) v = 32767;
      return 16'(v);
   endfunction

   // walking-like sequences of quiet and peak samples, with some noise
   task automatic run_walk(input int unsigned count);
      int unsigned n;
      int unsigned amp;
      logic        peak;
      logic signed [15:0] ax, ay, az, gx, gy, gz;
      peak = 1'b0;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(99, 0) < 20) begin
            send_request(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), $urandom);
         end else if ($urandom_range(99, 0) < 3) begin
            send_clear();
         end else begin
            if ($urandom_range(99, 0) < 75) peak = ~peak;
            amp = peak ? 32768 : 9000;
            ax  = axis_upto(amp);
            ay  = axis_upto(amp);
            az  = axis_upto(amp);
            amp = (peak && $urandom_range(99, 0) < 80) ? 32768 : 300;
            gx  = axis_upto(amp);
            gy  = axis_upto(amp);
            gz  = axis_upto(amp);
            if ($urandom_range(99, 0) < 4) walk_time = $urandom;
            else walk_time = walk_time + $urandom_range(250, 0);
            send_sample(ax, ay, az, gx, gy, gz, walk_time);
         end
      end
   endtask

   // default registers straight after reset: crossings, interval, gyro, wrap, clear
   task automatic test_default_thresholds;
      send_sample(0, 0, 0, 0, 0, 0, 32'd0);
      // interval exactly met is refused
      send_sample(32767, 0, 0, 32767, 32767, 32767, 32'd300);
      send_sample(0, 0, 0, 0, 0, 0, 32'd400);
      send_sample(32767, 0, 0, 32767, 32767, 32767, 32'd301);
      // still above: no new crossing
      send_sample(32767, 0, 0, 32767, 32767, 32767, 32'd1000);
      send_sample(100, -100, 0, 0, 0, 0, 32'd1100);
      // gyro at threshold suppresses the crossing but prev_above follows
      send_sample(0, -32768, 0, 640, 0, 0, 32'd1200);
      send_sample(0, 0, 32767, 641, 0, 0, 32'd1300);
      send_sample(0, 0, 0, 0, 0, 0, 32'd1400);
      send_sample(0, 0, 32767, 0, -641, 0, 32'd1500);
      send_sample(0, 0, 0, 0, 0, 0, 32'd1600);
      send_sample(-32768, -32768, -32768, -32768, -32768, -32768, 32'hFFFF_FFFF);
      send_sample(0, 0, 0, 0, 0, 0, 32'd0);
      // timestamp wrap: short elapsed refused, then just enough
      send_sample(32767, 0, 0, 32767, 32767, 32767, 32'h0000_0100);
      send_sample(0, 0, 0, 0, 0, 0, 32'd0);
      send_sample(32767, 0, 0, 32767, 32767, 32767, 32'd300);
      send_clear();
      // clear keeps the last step time
      send_sample(0, 0, 0, 0, 0, 0, 32'd0);
      send_sample(32767, 0, 0, 32767, 32767, 32767, 32'd600);
      send_sample(0, 0, 0, 0, 0, 0, 32'd0);
      send_sample(32767, 0, 0, 32767, 32767, 32767, 32'd601);
   endtask

   // zero registers: any non-zero vector is above, zero interval still needs time
   task automatic test_zero_thresholds;
      wait_drained();
      write_csr(CSR_ACC_THRESHOLD_SQ, 32'd0);
      write_csr(CSR_GYRO_THRESHOLD_SQ, 32'd0);
      write_csr(CSR_MIN_INTERVAL_MS, 32'hFFFF_0000);
      write_csr(CSR_UNUSED, $urandom);
      send_sample(0, 0, 0, 1, 0, 0, 32'd601);
      send_sample(1, 0, 0, 1, 0, 0, 32'd601);
      send_sample(0, 0, 0, 0, 0, 0, 32'd601);
      send_sample(0, -1, 0, 0, 0, -1, 32'd602);
      send_sample(0, 0, -1, 0, 0, 0, 32'd603);
      send_sample(0, 0, 0, 0, 0, 0, 32'd650);
      send_sample(0, 0, 1, 0, 0, 0, 32'd700);
   endtask

   // largest registers: the biggest vector only just fails or passes
   task automatic test_max_thresholds;
      wait_drained();
      set_config(32'hC000_0000, 32'hC000_0000, 32'h0000_FFFF);
      send_sample(0, 0, 0, 0, 0, 0, 32'd0);
      send_sample(-32768, -32768, -32768, -32768, -32768, -32768, 32'd200000);
      wait_drained();
      set_config(32'hBFFF_FFFF, 32'hBFFF_FFFF, 32'h0000_FFFF);
      send_sample(0, 0, 0, 0, 0, 0, 32'd0);
      send_sample(-32768, -32768, -32768, -32768, -32768, -32768, 32'd66137);
      send_sample(0, 0, 0, 0, 0, 0, 32'd0);
      send_sample(-32768, -32768, -32768, -32768, -32768, -32768, 32'd66138);
   endtask

   // count a run of back-to-back steps, then clear and count again
   task automatic test_count_run;
      int unsigned n;
      logic [31:0] t;
      wait_drained();
      set_config(32'd0, 32'd0, 32'd0);
      gaps_enabled = 1'b0;
      t = 32'd66139;
      for (n = 0; n < 40; n++) begin
         send_sample(0, 0, 0, 0, 0, 0, t);
         send_sample(1, 0, 0, 1, 0, 0, t);
         t = t + 32'd1;
      end
      send_request(OP_CLEAR, -1, -1, -1, -1, -1, -1, 32'hFFFF_FFFF);
      send_sample(0, 0, 0, 0, 0, 0, t);
      send_sample(1, 0, 0, 1, 0, 0, t);
      gaps_enabled = 1'b1;
   endtask

   // hold results off while requests keep coming, then drain fully
   task automatic test_backpressure;
      wait_drained();
      set_config(ACC_THRESHOLD_RESET, GYRO_THRESHOLD_RESET, {16'h0, MIN_INTERVAL_RESET});
      gaps_enabled    = 1'b0;
      rsp_hold_cycles = 80;
      run_walk(30);
      wait_drained();
      gaps_enabled = 1'b1;
   endtask

   // random walking under several register settings
   task automatic test_random_walks;
      int unsigned phase;
      wait_drained();
      set_config(ACC_THRESHOLD_RESET, GYRO_THRESHOLD_RESET,
                 {16'($urandom), MIN_INTERVAL_RESET});
      run_walk(400);
      wait_drained();
      set_config(32'd0, 32'd0, 32'd0);
      run_walk(100);
      wait_drained();
      set_config(32'hC000_0000, 32'hC000_0000, {16'($urandom), 16'hFFFF});
      run_walk(100);
      for (phase = 0; phase < 3; phase++) begin
         wait_drained();
         gaps_enabled = (phase != 1);
         set_config($urandom_range(600_000_000, 20_000_000), $urandom_range(3_000_000, 0),
                    {16'($urandom), 16'($urandom_range(600, 0))});
         run_walk(250);
      end
      gaps_enabled = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_SAMPLE;
      req_acc_x        = '0;
      req_acc_y        = '0;
      req_acc_z        = '0;
      req_gyro_x       = '0;
      req_gyro_y       = '0;
      req_gyro_z       = '0;
      req_time_ms      = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_ACC_THRESHOLD_SQ;
      csr_data         = '0;
      model_cfg.acc_threshold_sq  = ACC_THRESHOLD_RESET;
      model_cfg.gyro_threshold_sq = GYRO_THRESHOLD_RESET;
      model_cfg.min_interval_ms   = MIN_INTERVAL_RESET;
      model_prev_above   = 1'b0;
      model_last_step_ms = '0;
      model_steps        = '0;
      mismatch_count     = 0;
      gaps_enabled       = 1'b1;
      rsp_hold_cycles    = 0;
      walk_time          = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_thresholds();
      test_zero_thresholds();
      test_max_thresholds();
      test_count_run();
      test_backpressure();
      test_random_walks();

      // drain and allow the pipeline to settle
      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_steps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
src/isd_pkg.sv
src/isd_square_lane.sv
src/isd_merge.sv
src/imu_step_detector_unit.sv
tb/tb_imu_step_detector_unit.sv
